[rtl/functional_graph_cycle_min_cost_core_defines.svh]
// Assertion macros shared by the functional graph cycle cost core.
`ifndef FUNCTIONAL_GRAPH_CYCLE_MIN_COST_CORE_DEFINES_SVH
`define FUNCTIONAL_GRAPH_CYCLE_MIN_COST_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clk outside reset.
`define FGCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FGCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/fgcm_pkg.sv]
// Package: sizes, microcode step and control word types, and the microcode table.
package fgcm_pkg;

  localparam int MAX_NODES = 1024;
  localparam int COST_BITS = 32;

  localparam int SUCC_W     = 10;
  localparam int IN_COST_W  = 32;
  localparam int TOTAL_W    = 42;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 48;

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam int CNT_W = $clog2(MAX_NODES + 1);
  localparam int CMP_W = (SUCC_W > CNT_W) ? SUCC_W : CNT_W;
  localparam int SUM_W = ((TOTAL_W > COST_BITS) ? TOTAL_W : COST_BITS) + 1;

  localparam int STEP_W = 4;

  typedef enum logic [STEP_W-1:0] {
    ST_EMIT  = 4'd0,
    ST_LOAD  = 4'd1,
    ST_CHK   = 4'd2,
    ST_START = 4'd3,
    ST_TEST  = 4'd4,
    ST_STEP  = 4'd5,
    ST_CLOSE = 4'd6,
    ST_CINIT = 4'd7,
    ST_CMIN  = 4'd8,
    ST_ADD   = 4'd9,
    ST_NEXT  = 4'd10
  } step_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_NOT_LAST,
    C_BAD,
    C_DONE,
    C_MARKED,
    C_NOT_OWN,
    C_LOOP_END,
    C_NOT_LOOP_END,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    ADDR_S,
    ADDR_V,
    ADDR_NXT
  } addr_sel_t;

  typedef enum logic [1:0] {
    V_HOLD,
    V_FROM_S,
    V_FROM_NXT
  } vsrc_t;

  typedef struct packed {
    logic      in_rdy;
    addr_sel_t addr_sel;
    vsrc_t     v_src;
    logic      s_clr;
    logic      s_inc;
    logic      id_ld;
    logic      mark_wr;
    logic      best_ld;
    logic      best_min;
    logic      tot_clr;
    logic      tot_add;
    logic      emit;
    cond_t     cond;
    step_t     target;
  } ctrl_t;

  typedef struct packed {
    logic last_beat;
    logic bad;
    logic done;
    logic marked;
    logic own;
    logic loop_end;
    logic out_busy;
  } flags_t;

  // Microcode table: one control word per step; a false condition falls through.
  function automatic ctrl_t ucode(input step_t st);
    ctrl_t cw;
    cw = '0;
    case (st)
      ST_EMIT: begin
        cw.emit   = 1'b1;
        cw.cond   = C_OUT_BUSY;
        cw.target = ST_EMIT;
      end
      ST_LOAD: begin
        cw.in_rdy = 1'b1;
        cw.cond   = C_NOT_LAST;
        cw.target = ST_LOAD;
      end
      ST_CHK: begin
        cw.s_clr   = 1'b1;
        cw.tot_clr = 1'b1;
        cw.cond    = C_BAD;
        cw.target  = ST_EMIT;
      end
      ST_START: begin
        cw.addr_sel = ADDR_S;
        cw.v_src    = V_FROM_S;
        cw.id_ld    = 1'b1;
        cw.cond     = C_DONE;
        cw.target   = ST_EMIT;
      end
      ST_TEST: begin
        cw.addr_sel = ADDR_V;
        cw.mark_wr  = 1'b1;
        cw.cond     = C_MARKED;
        cw.target   = ST_CLOSE;
      end
      ST_STEP: begin
        cw.addr_sel = ADDR_NXT;
        cw.v_src    = V_FROM_NXT;
        cw.cond     = C_ALWAYS;
        cw.target   = ST_TEST;
      end
      ST_CLOSE: begin
        cw.addr_sel = ADDR_V;
        cw.cond     = C_NOT_OWN;
        cw.target   = ST_NEXT;
      end
      ST_CINIT: begin
        cw.addr_sel = ADDR_NXT;
        cw.best_ld  = 1'b1;
        cw.cond     = C_LOOP_END;
        cw.target   = ST_ADD;
      end
      ST_CMIN: begin
        cw.addr_sel = ADDR_NXT;
        cw.best_min = 1'b1;
        cw.cond     = C_NOT_LOOP_END;
        cw.target   = ST_CMIN;
      end
      ST_ADD: begin
        cw.tot_add = 1'b1;
        cw.cond    = C_NONE;
        cw.target  = ST_NEXT;
      end
      ST_NEXT: begin
        cw.s_inc  = 1'b1;
        cw.cond   = C_ALWAYS;
        cw.target = ST_START;
      end
      default: begin
        cw.cond   = C_ALWAYS;
        cw.target = ST_LOAD;
      end
    endcase
    return cw;
  endfunction

endpackage

[rtl/fgcm_seq.sv]
// Microcode sequencer: step counter, control word lookup and conditional jumps.
module fgcm_seq import fgcm_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  flags_t flags,
  output ctrl_t  cw
);

  step_t pc;
  step_t pc_next;
  logic  take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ST_LOAD;
    end else begin
      pc <= pc_next;
    end
  end

  // Output: control word of the current step.
  always_comb begin
    cw = ucode(pc);
  end

  // Next step.
  always_comb begin
    case (cw.cond)
      C_NONE:         take = 1'b0;
      C_ALWAYS:       take = 1'b1;
      C_NOT_LAST:     take = !flags.last_beat;
      C_BAD:          take = flags.bad;
      C_DONE:         take = flags.done;
      C_MARKED:       take = flags.marked;
      C_NOT_OWN:      take = !flags.own;
      C_LOOP_END:     take = flags.loop_end;
      C_NOT_LOOP_END: take = !flags.loop_end;
      C_OUT_BUSY:     take = flags.out_busy;
      default:        take = 1'b0;
    endcase
    pc_next = take ? cw.target : step_t'(pc + STEP_W'(1));
  end

endmodule

[rtl/fgcm_dp.sv]
// Datapath: node tables, walk marks, walk registers and the saturating total.
module fgcm_dp import fgcm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  ctrl_t                cw,
  input  logic                 in_acc,
  input  logic                 in_last,
  input  logic                 out_busy,
  input  logic [SUCC_W-1:0]    successor,
  input  logic [IN_COST_W-1:0] edge_cost,
  output flags_t               flags,
  output logic [TOTAL_W-1:0]   total,
  output logic                 bad
);

  logic [IDX_W-1:0]     next_mem [MAX_NODES];
  logic [COST_BITS-1:0] cost_mem [MAX_NODES];
  logic [CNT_W-1:0]     mark_mem [MAX_NODES];

  logic [IDX_W-1:0]     next_q;
  logic [COST_BITS-1:0] cost_q;
  logic [CNT_W-1:0]     mark_q;

  logic [CNT_W-1:0]     cnt;
  logic [SUCC_W-1:0]    max_succ;
  logic [CNT_W-1:0]     s;
  logic [CNT_W-1:0]     id;
  logic [IDX_W-1:0]     v;
  logic [COST_BITS-1:0] best;

  logic [IDX_W-1:0]     rd_addr;
  logic                 load_wr;
  logic                 mark_we;
  logic [IDX_W-1:0]     mark_wa;
  logic [CNT_W-1:0]     mark_wd;
  logic                 emit_fire;
  logic [SUM_W-1:0]     sum;

  always_comb begin
    case (cw.addr_sel)
      ADDR_S:   rd_addr = s[IDX_W-1:0];
      ADDR_V:   rd_addr = v;
      ADDR_NXT: rd_addr = next_q;
      default:  rd_addr = v;
    endcase
  end

  assign load_wr   = in_acc && (cnt < CNT_W'(MAX_NODES));
  // Marks are zeroed as nodes load, so every entry below the count starts clear.
  assign mark_we   = load_wr || (cw.mark_wr && (mark_q == '0));
  assign mark_wa   = load_wr ? cnt[IDX_W-1:0] : v;
  assign mark_wd   = load_wr ? '0 : id;
  assign emit_fire = cw.emit && !out_busy;
  assign bad       = CMP_W'(max_succ) >= CMP_W'(cnt);
  assign sum       = SUM_W'(total) + SUM_W'(best);

  always_ff @(posedge clk) begin
    if (load_wr) begin
      next_mem[cnt[IDX_W-1:0]] <= IDX_W'(successor);
      cost_mem[cnt[IDX_W-1:0]] <= COST_BITS'(edge_cost);
    end
    if (mark_we) begin
      mark_mem[mark_wa] <= mark_wd;
    end
    next_q <= next_mem[rd_addr];
    cost_q <= cost_mem[rd_addr];
    mark_q <= mark_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      max_succ <= '0;
    end else if (emit_fire) begin
      cnt      <= '0;
      max_succ <= '0;
    end else if (load_wr) begin
      cnt <= cnt + CNT_W'(1);
      if (successor > max_succ) begin
        max_succ <= successor;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cw.s_clr) begin
      s <= '0;
    end else if (cw.s_inc) begin
      s <= s + CNT_W'(1);
    end
    if (cw.id_ld) begin
      id <= s + CNT_W'(1);
    end
    case (cw.v_src)
      V_FROM_S:   v <= s[IDX_W-1:0];
      V_FROM_NXT: v <= next_q;
      default:    v <= v;
    endcase
    if (cw.best_ld) begin
      best <= cost_q;
    end else if (cw.best_min && (cost_q < best)) begin
      best <= cost_q;
    end
    if (cw.tot_clr) begin
      total <= '0;
    end else if (cw.tot_add) begin
      total <= (|sum[SUM_W-1:TOTAL_W]) ? {TOTAL_W{1'b1}} : sum[TOTAL_W-1:0];
    end
  end

  assign flags.last_beat = in_acc && in_last;
  assign flags.bad       = bad;
  assign flags.done      = (s == cnt);
  assign flags.marked    = (mark_q != '0);
  assign flags.own       = (mark_q == id);
  assign flags.loop_end  = (next_q == v);
  assign flags.out_busy  = out_busy;

endmodule

[rtl/functional_graph_cycle_min_cost_core.sv]
// Top level: stream ports, result register, sequencer and datapath.
// Nodes load one per beat while s_axis_tready is high; a beat with tlast set ends the
// graph, after which the input stays stalled while the block walks the graph: from each
// start node not yet marked it marks fresh nodes in turn, and for every cycle found it
// walks the cycle once more and adds its cheapest edge to the total. Each node table has
// a single read port. The result goes to the output register only once the previous
// result has been taken. An out-of-range successor is caught before the walk, which it
// skips. The result sits in an output register, so loading of the next graph goes on
// while it waits to be taken.
`include "functional_graph_cycle_min_cost_core_defines.svh"
module functional_graph_cycle_min_cost_core import fgcm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // successor[9:0], edge_cost[41:10], zero pad
  input  logic                  s_axis_tlast,   // last_node
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,   // cycle_cost_total[41:0], zero pad
  output logic                  m_axis_tuser    // bad_successor
);

  ctrl_t                cw;
  flags_t               flags;
  logic                 in_acc;
  logic                 out_busy;
  logic [TOTAL_W-1:0]   total;
  logic                 bad;
  logic [TOTAL_W-1:0]   out_total;
  logic                 out_bad;

  assign s_axis_tready = cw.in_rdy;
  assign in_acc        = s_axis_tvalid && cw.in_rdy;
  assign out_busy      = m_axis_tvalid && !m_axis_tready;

  fgcm_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .cw    (cw)
  );

  fgcm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cw        (cw),
    .in_acc    (in_acc),
    .in_last   (s_axis_tlast),
    .out_busy  (out_busy),
    .successor (s_axis_tdata[SUCC_W-1:0]),
    .edge_cost (s_axis_tdata[SUCC_W +: IN_COST_W]),
    .flags     (flags),
    .total     (total),
    .bad       (bad)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cw.emit && !out_busy) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cw.emit && !out_busy) begin
      out_total <= total;
      out_bad   <= bad;
    end
  end

  assign m_axis_tdata = OUT_DATA_W'(out_total);
  assign m_axis_tuser = out_bad;

  `FGCM_ASSERT_NOW(a_bad_zero, m_axis_tvalid && m_axis_tuser, out_total == '0, "bad graph with nonzero total")
  `FGCM_ASSERT_NEXT(a_last_stalls, in_acc && s_axis_tlast, !s_axis_tready, "input open after last beat")
  `FGCM_ASSERT_NOW(a_emit_not_loading, $rose(m_axis_tvalid), !$past(s_axis_tready), "result during load")

endmodule

[tb/functional_graph_cycle_min_cost_core_tb.sv]
// Testbench for the functional graph cycle cost core: directed and random graphs, self-checked.
`timescale 1ns / 100ps
module functional_graph_cycle_min_cost_core_tb;
  import fgcm_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 310;
  localparam logic [63:0] TOTAL_SAT = (64'd1 << TOTAL_W) - 64'd1;
  localparam logic [63:0] COST_KEEP = (64'd1 << COST_BITS) - 64'd1;

  typedef struct {
    logic [TOTAL_W-1:0] total;
    logic               bad;
  } graph_result_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // successor[9:0], edge_cost[41:10], zero pad
  logic                  s_axis_tlast;   // last_node
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [OUT_DATA_W-1:0] m_axis_tdata;   // cycle_cost_total[41:0], zero pad
  logic                  m_axis_tuser;   // bad_successor

  functional_graph_cycle_min_cost_core dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // predictor state: nodes of the graph being loaded
  logic [SUCC_W-1:0] succ_tab [MAX_NODES];
  logic [63:0]       cost_tab [MAX_NODES];
  int unsigned       walk_id  [MAX_NODES];
  int unsigned       node_cnt;

  graph_result_t     result_q [$];
  logic [SUCC_W-1:0] pend_succ [$];
  logic [31:0]       pend_cost [$];

  int  err_cnt = 0;
  int  cycle_cnt = 0;
  int  items_sent;
  bit  idle_en;
  int  stall_left = 0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (idle_en && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(1, 10) - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  // compare each result beat with the oldest prediction
  always @(posedge clk) begin
    graph_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (result_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display("unexpected result beat: total=%0h bad=%0b",
                   m_axis_tdata[TOTAL_W-1:0], m_axis_tuser);
      end else begin
        want = result_q.pop_front();
        if (m_axis_tdata[TOTAL_W-1:0] !== want.total || m_axis_tuser !== want.bad) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("result mismatch: expected total=%0h bad=%0b, got total=%0h bad=%0b",
                     want.total, want.bad, m_axis_tdata[TOTAL_W-1:0], m_axis_tuser);
        end
      end
    end
  end

  // sum of the cheapest edge of every cycle; walks mark nodes with the start index + 1
  function automatic graph_result_t predict_cycle_cost();
    graph_result_t res;
    logic [63:0]   run_sum;
    logic [63:0]   best;
    int unsigned   v;
    int unsigned   u;
    res.bad = 1'b0;
    run_sum = 64'd0;
    for (int unsigned i = 0; i < node_cnt; i++)
      if (succ_tab[i] >= node_cnt)
        res.bad = 1'b1;
    if (!res.bad) begin
      for (int unsigned i = 0; i < node_cnt; i++)
        walk_id[i] = 0;
      for (int unsigned s = 0; s < node_cnt; s++) begin
        if (walk_id[s] == 0) begin
          v = s;
          while (walk_id[v] == 0) begin
            walk_id[v] = s + 1;
            v = succ_tab[v];
          end
          if (walk_id[v] == s + 1) begin
            best = cost_tab[v];
            u = succ_tab[v];
            while (u != v) begin
              if (cost_tab[u] < best)
                best = cost_tab[u];
              u = succ_tab[u];
            end
            if (best > TOTAL_SAT || run_sum > TOTAL_SAT - best)
              run_sum = TOTAL_SAT;
            else
              run_sum = run_sum + best;
          end
        end
      end
    end
    res.total = res.bad ? '0 : run_sum[TOTAL_W-1:0];
    return res;
  endfunction

  // one input beat; called and returns at a falling edge, tvalid left high
  task automatic send_node(input logic [SUCC_W-1:0] succ, input logic [31:0] cost,
                           input logic last);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 10)) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {{(IN_DATA_W - SUCC_W - 32){1'b0}}, cost, succ};
    s_axis_tlast  = last;
    do @(posedge clk); while (!s_axis_tready);
    items_sent++;
    if (node_cnt < MAX_NODES) begin
      succ_tab[node_cnt] = succ;
      cost_tab[node_cnt] = {32'd0, cost} & COST_KEEP;
      node_cnt++;
    end
    if (last) begin
      result_q.insert(result_q.size(), predict_cycle_cost());
      node_cnt = 0;
    end
    @(negedge clk);
  endtask

  task automatic add_node(input int unsigned succ, input logic [31:0] cost);
    pend_succ.insert(pend_succ.size(), succ[SUCC_W-1:0]);
    pend_cost.insert(pend_cost.size(), cost);
  endtask

  task automatic send_graph();
    int n;
    n = pend_succ.size();
    for (int i = 0; i < n; i++)
      send_node(pend_succ[i], pend_cost[i], i == n - 1);
    pend_succ.delete();
    pend_cost.delete();
    s_axis_tvalid = 1'b0;
    s_axis_tlast  = 1'b0;
  endtask

  task automatic wait_results_done();
    while (result_q.size() != 0) @(negedge clk);
  endtask

  function automatic logic [31:0] pick_cost();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // shapes: 0-2 uniform, 3 permutation, 4 mostly self-loops, 5 one successor out of range
  task automatic build_random_graph(input int n, input int shape);
    int unsigned perm [$];
    int unsigned tmp;
    int          j;
    int          bad_at;
    for (int i = 0; i < n; i++)
      perm.insert(perm.size(), i);
    for (int i = n - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = perm[i];
      perm[i] = perm[j];
      perm[j] = tmp;
    end
    bad_at = $urandom_range(0, n - 1);
    for (int i = 0; i < n; i++) begin
      case (shape)
        3: add_node(perm[i], pick_cost());
        4: add_node($urandom_range(0, 2) != 0 ? i : $urandom_range(0, n - 1), pick_cost());
        5: add_node(i == bad_at ? $urandom_range(n, 1023) : $urandom_range(0, n - 1),
                    pick_cost());
        default: add_node($urandom_range(0, n - 1), pick_cost());
      endcase
    end
  endtask

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom_range(13, 40);
      2:       return ($urandom_range(0, 3) == 0) ? $urandom_range(100, 300) : 3;
      default: return $urandom_range(1, 12);
    endcase
  endfunction

  task automatic test_directed();
    idle_en = 1'b1;
    add_node(0, 32'd0);                // lone self-loop, zero cost
    send_graph();
    add_node(0, 32'hFFFF_FFFF);        // lone self-loop, largest cost
    send_graph();
    add_node(1, 32'd7);                // successor equal to node count
    send_graph();
    add_node(1023, 32'hFFFF_FFFF);     // largest successor value
    send_graph();
    add_node(1, 32'd5);
    add_node(0, 32'd3);
    send_graph();
    // tail into a loop of three nodes; the cheap tail edge must not count
    add_node(1, 32'd1);
    add_node(2, 32'd9);
    add_node(3, 32'd7);
    add_node(1, 32'd8);
    send_graph();
    // self-loop plus a loop of two nodes, and a zero-cost tail into the self-loop
    add_node(0, 32'd4);
    add_node(2, 32'd10);
    add_node(1, 32'd6);
    add_node(0, 32'd0);
    send_graph();
    // out-of-range successor in the middle
    add_node(1, 32'd2);
    add_node(3, 32'd2);
    add_node(0, 32'd2);
    send_graph();
  endtask

  // sender holds off until the block has drained
  task automatic test_drain_pause();
    idle_en = 1'b1;
    build_random_graph(6, 0);
    send_graph();
    wait_results_done();
    build_random_graph(5, 3);
    send_graph();
  endtask

  task automatic test_random_graphs();
    int start;
    int n;
    start = items_sent;
    while (items_sent - start < RANDOM_ITEMS) begin
      idle_en = ($urandom_range(0, 4) != 0);
      n = pick_size();
      if (n > RANDOM_ITEMS - (items_sent - start))
        n = RANDOM_ITEMS - (items_sent - start);
      build_random_graph(n, $urandom_range(0, 5));
      send_graph();
    end
  endtask

  task automatic test_back_to_back();
    int start;
    idle_en = 1'b0;
    start = items_sent;
    while (items_sent - start < 60) begin
      build_random_graph($urandom_range(1, 12), $urandom_range(0, 5));
      send_graph();
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tlast  = 1'b0;
    idle_en       = 1'b0;
    items_sent    = 0;
    node_cnt      = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_drain_pause();
    test_random_graphs();
    test_back_to_back();

    wait_results_done();
    repeat (300) @(negedge clk);
    if (err_cnt == 0 && result_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/fgcm_pkg.sv
rtl/fgcm_seq.sv
rtl/fgcm_dp.sv
rtl/functional_graph_cycle_min_cost_core.sv
tb/functional_graph_cycle_min_cost_core_tb.sv
